// ===== rtl/core/bal_pkg.sv =====
// shared operation codes, beat layout and controller command struct for the array list
package bal_pkg;

	// operation codes carried in the input tuser
	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_APPEND    = 3'd1;
	localparam logic [2:0] OP_INS_POS   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_END   = 3'd4;
	localparam logic [2:0] OP_DEL_POS   = 3'd5;
	localparam logic [2:0] OP_SEARCH    = 3'd6;

	// field widths fixed by the beat format
	localparam int OP_W    = 3;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 3;
	localparam int LEN_W   = 4;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;   // latch the accepted input beat
		logic exec;      // apply the operation to the cells and count
		logic reduce;    // fold match bits into the result flag
		logic load_out;  // move the result into the output register
	} bal_cmd_t;

endpackage

// ===== rtl/core/bal_ctrl.sv =====
// sequencing state machine: accept, execute, reduce, deliver
module bal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output bal_pkg::bal_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIND,
		ST_SEND
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	// commands decoded from the current state
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.reduce   = (state_q == ST_FIND);
		cmd.load_out = (state_q == ST_SEND) && out_free;
	end

	// state and output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// a new result takes the slot, otherwise a taken beat frees it
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/bal_datapath.sv =====
// entry cells with neighbour shifting, count, per-cell compare and result registers
module bal_datapath #(
	parameter int DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bal_pkg::bal_cmd_t              cmd,
	input  logic [bal_pkg::OP_W-1:0]       op_in,
	input  logic [bal_pkg::VAL_W-1:0]      value_in,
	input  logic [bal_pkg::POS_W-1:0]      position_in,
	output logic                           ok_out,
	output logic [bal_pkg::LEN_W-1:0]      length_out
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W;
	localparam int MW = (CW > bal_pkg::LEN_W) ? CW : bal_pkg::LEN_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [bal_pkg::OP_W-1:0]  op_q;
	logic [bal_pkg::VAL_W-1:0] val_q;
	logic [bal_pkg::POS_W-1:0] pos_q;
	logic [bal_pkg::VAL_W-1:0] cells_q [DEPTH];
	logic [bal_pkg::VAL_W-1:0] cells_d [DEPTH];
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;
	logic [DEPTH-1:0]          match_q;
	logic [DEPTH-1:0]          match_d;
	logic                      op_ok_q;
	logic                      op_ok_d;
	logic                      is_search_q;
	logic                      res_ok_q;
	logic                      out_ok_q;
	logic [bal_pkg::LEN_W-1:0] out_len_q;

	logic          full;
	logic          empty;
	logic          pos_below;
	logic          shift_up;
	logic          shift_down;
	logic [PW-1:0] gap;
	logic [PW-1:0] count_ext;
	logic [MW-1:0] len_ext;

	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign count_ext = PW'(count_q);
	assign pos_below = (PW'(pos_q) < count_ext);

	// operation decode: legality, gap position, direction of the shift and the next count
	always_comb begin
		op_ok_d    = 1'b0;
		shift_up   = 1'b0;
		shift_down = 1'b0;
		gap        = '0;
		count_d    = count_q;
		unique case (op_q)
			bal_pkg::OP_INS_FRONT: begin
				op_ok_d  = !full;
				shift_up = !full;
				gap      = '0;
			end
			bal_pkg::OP_APPEND: begin
				op_ok_d  = !full;
				shift_up = !full;
				gap      = count_ext;
			end
			bal_pkg::OP_INS_POS: begin
				op_ok_d  = !full && pos_below;
				shift_up = !full && pos_below;
				gap      = PW'(pos_q);
			end
			bal_pkg::OP_DEL_FRONT: begin
				op_ok_d    = !empty;
				shift_down = !empty;
				gap        = '0;
			end
			bal_pkg::OP_DEL_END: begin
				op_ok_d = !empty;
			end
			bal_pkg::OP_DEL_POS: begin
				op_ok_d    = pos_below;
				shift_down = pos_below;
				gap        = PW'(pos_q);
			end
			default: begin
				op_ok_d = 1'b0;
			end
		endcase
		if (op_ok_d && shift_up) begin
			count_d = count_q + 1'b1;
		end else if (op_ok_d) begin
			count_d = count_q - 1'b1;
		end
	end

	// per-cell next value and compare, each cell sees only its neighbours
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [bal_pkg::VAL_W-1:0] below_val;
		logic [bal_pkg::VAL_W-1:0] above_val;

		if (g == 0) begin : g_bot
			assign below_val = val_q;
		end else begin : g_mid
			assign below_val = cells_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_top
			assign above_val = cells_q[g];
		end else begin : g_low
			assign above_val = cells_q[g+1];
		end

		always_comb begin
			cells_d[g] = cells_q[g];
			if (shift_up && (PW'(g) == gap)) begin
				cells_d[g] = val_q;
			end else if (shift_up && (PW'(g) > gap)) begin
				cells_d[g] = below_val;
			end else if (shift_down && (PW'(g) >= gap)) begin
				cells_d[g] = above_val;
			end
		end

		assign match_d[g] = (cells_q[g] == val_q) && (PW'(g) < count_ext);
	end

	// captured input beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_in;
			val_q <= value_in;
			pos_q <= position_in;
		end
	end

	// entry cells, written when the operation executes
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				cells_q[i] <= cells_d[i];
			end
		end
	end

	// stored entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// operation flag, match bits and result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			op_ok_q     <= op_ok_d;
			match_q     <= match_d;
			is_search_q <= (op_q == bal_pkg::OP_SEARCH);
		end
		if (cmd.reduce) begin
			res_ok_q <= is_search_q ? (|match_q) : op_ok_q;
		end
		if (cmd.load_out) begin
			out_ok_q  <= res_ok_q;
			out_len_q <= len_ext[bal_pkg::LEN_W-1:0];
		end
	end

	assign len_ext    = MW'(count_q);
	assign ok_out     = out_ok_q;
	assign length_out = out_len_q;

endmodule

// ===== rtl/core/bounded_array_list.sv =====
// top level of the bounded array list
//
// Ordered list of up to DEPTH signed 32-bit values held in a row of register cells.
// Each input beat carries one operation (insert front, append, insert at position,
// delete front, delete end, delete at position, search) and yields exactly one
// output beat with a success or found flag and the entry count afterwards, taken
// modulo 16. The accepting edge latches the input beat; the execute state then lets
// every cell shift from its neighbour and compare its value at once, the find state
// folds the match bits, and the send state loads the output register once the output
// slot is free. The next input beat is accepted only after the machine is back in
// idle, so no new item is taken before the result of the last is loaded. Stored
// entries need no clearing after reset; only the count resets.
module bounded_array_list #(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[34:32], zero[39:35]
	input  logic [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // ok[0], length[4:1], zero[7:5]
);

	bal_pkg::bal_cmd_t             cmd;
	logic                          ok;
	logic [bal_pkg::LEN_W-1:0]     length;

	// sequencing
	bal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// cells, count and result
	bal_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op_in       (s_tuser),
		.value_in    (s_tdata[31:0]),
		.position_in (s_tdata[34:32]),
		.ok_out      (ok),
		.length_out  (length)
	);

	// output beat packing
	assign m_tdata = {3'b000, length, ok};

endmodule

// ===== sim/tb_top.sv =====
// testbench for the bounded array list: directed table, then weighted random list operations
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH = 8;
	localparam int RANDOM_ITEMS = 600;
	localparam int MAX_SHOWN = 10;
	// code 7 has no operation behind it
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic       ok;
		logic [3:0] length;
	} list_result_t;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] value;
		logic [2:0]  pos;
		bit          typed;
		logic        ok;
		logic [3:0]  length;
	} list_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // value[31:0], position[34:32], zero[39:35]
	logic [2:0]  s_tuser;   // operation[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // ok[0], length[4:1], zero[7:5]

	// shadow copy of the list
	logic [31:0]  shadow_vals [DEPTH];
	int unsigned  shadow_len;
	list_result_t pending_results [$];
	int unsigned  mismatch_cnt;
	bit           calm;

	// directed rows; typed results are the ones obvious from the list state
	localparam int N_ROWS = 25;
	list_row_t plan_rows [N_ROWS] = '{
		'{bal_pkg::OP_SEARCH,    32'h0000_0000, 3'd0, 1'b1, 1'b0, 4'd0},
		'{bal_pkg::OP_DEL_FRONT, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 4'd0},
		'{bal_pkg::OP_DEL_END,   32'h0000_0000, 3'd0, 1'b1, 1'b0, 4'd0},
		'{bal_pkg::OP_DEL_POS,   32'h0000_0000, 3'd0, 1'b1, 1'b0, 4'd0},
		'{bal_pkg::OP_INS_POS,   32'h0000_0001, 3'd0, 1'b1, 1'b0, 4'd0},
		'{OP_UNUSED,             32'h0000_0000, 3'd0, 1'b1, 1'b0, 4'd0},
		'{bal_pkg::OP_APPEND,    32'h7fff_ffff, 3'd0, 1'b1, 1'b1, 4'd1},
		'{bal_pkg::OP_INS_FRONT, 32'h8000_0000, 3'd0, 1'b1, 1'b1, 4'd2},
		'{bal_pkg::OP_SEARCH,    32'h8000_0000, 3'd0, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_SEARCH,    32'h0000_0000, 3'd0, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_INS_POS,   32'hffff_ffff, 3'd1, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_APPEND,    32'h0000_0000, 3'd0, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_INS_POS,   32'h5555_aaaa, 3'd3, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_INS_FRONT, 32'haaaa_5555, 3'd0, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_INS_POS,   32'h1234_5678, 3'd5, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_APPEND,    32'hfedc_ba98, 3'd0, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_APPEND,    32'h0000_0001, 3'd0, 1'b1, 1'b0, 4'd8},
		'{bal_pkg::OP_INS_FRONT, 32'h0000_0002, 3'd0, 1'b1, 1'b0, 4'd8},
		'{bal_pkg::OP_INS_POS,   32'h0000_0003, 3'd7, 1'b1, 1'b0, 4'd8},
		'{bal_pkg::OP_SEARCH,    32'hfedc_ba98, 3'd0, 1'b0, 1'b0, 4'd0},
		'{bal_pkg::OP_DEL_POS,   32'h0000_0000, 3'd7, 1'b1, 1'b1, 4'd7},
		'{bal_pkg::OP_DEL_POS,   32'h0000_0000, 3'd7, 1'b1, 1'b0, 4'd7},
		'{bal_pkg::OP_DEL_FRONT, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 4'd6},
		'{bal_pkg::OP_DEL_END,   32'h0000_0000, 3'd0, 1'b1, 1'b1, 4'd5},
		'{OP_UNUSED,             32'h0000_0000, 3'd0, 1'b1, 1'b0, 4'd5}
	};

	bounded_array_list #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic logic [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			4, 5: return 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// make room at index at, moving entries upward from the top
	task automatic shift_up(input int unsigned at);
		int unsigned i;
		for (i = shadow_len; i > at; i--)
			shadow_vals[i] = shadow_vals[i - 1];
	endtask

	// close the hole at index at
	task automatic shift_down(input int unsigned at);
		int unsigned i;
		for (i = at; i + 1 < shadow_len; i++)
			shadow_vals[i] = shadow_vals[i + 1];
	endtask

	// apply one operation to the shadow list and give the flag it reports
	task automatic predict_list_op(input logic [2:0] op, input logic [31:0] value,
			input logic [2:0] pos, output logic ok);
		bit full;
		int unsigned i;
		full = (shadow_len >= DEPTH);
		ok = 1'b0;
		case (op)
			bal_pkg::OP_INS_FRONT: begin
				if (!full) begin
					shift_up(0);
					shadow_vals[0] = value;
					shadow_len++;
					ok = 1'b1;
				end
			end
			bal_pkg::OP_APPEND: begin
				if (!full) begin
					shadow_vals[shadow_len] = value;
					shadow_len++;
					ok = 1'b1;
				end
			end
			bal_pkg::OP_INS_POS: begin
				if (!full && pos < shadow_len) begin
					shift_up(pos);
					shadow_vals[pos] = value;
					shadow_len++;
					ok = 1'b1;
				end
			end
			bal_pkg::OP_DEL_FRONT: begin
				if (shadow_len > 0) begin
					shift_down(0);
					shadow_len--;
					ok = 1'b1;
				end
			end
			bal_pkg::OP_DEL_END: begin
				if (shadow_len > 0) begin
					shadow_len--;
					ok = 1'b1;
				end
			end
			bal_pkg::OP_DEL_POS: begin
				if (pos < shadow_len) begin
					shift_down(pos);
					shadow_len--;
					ok = 1'b1;
				end
			end
			bal_pkg::OP_SEARCH: begin
				for (i = 0; i < shadow_len; i++)
					if (shadow_vals[i] == value)
						ok = 1'b1;
			end
			default: begin
			end
		endcase
	endtask

	// present one beat after a random gap and queue what it should return
	task automatic send_list_op(input logic [2:0] op, input logic [31:0] value,
			input logic [2:0] pos, input bit typed, input logic t_ok, input logic [3:0] t_len);
		int unsigned gap;
		logic ok;
		list_result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 40'({$urandom, $urandom});
			s_tuser  <= 3'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, pos, value};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		predict_list_op(op, value, pos, ok);
		res.ok     = ok;
		res.length = 4'(shadow_len);
		if (typed) begin
			res.ok     = t_ok;
			res.length = t_len;
		end
		pending_results.push_back(res);
		@(negedge clk);
	endtask

	task automatic note_mismatch(input string what, input list_result_t want,
			input list_result_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_SHOWN)
			$display("mismatch (%s): expected ok=%0b length=%0d, got ok=%0b length=%0d",
				what, want.ok, want.length, got.ok, got.length);
	endtask

	// output side back-pressure
	initial begin
		int unsigned hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
			end else begin
				hold = pick_gap();
				m_tready <= (hold == 0);
			end
		end
	end

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok     = m_tdata[0];
			got.length = m_tdata[4:1];
			if (pending_results.size() == 0) begin
				want = '0;
				note_mismatch("beat with nothing expected", want, got);
			end else begin
				want = pending_results.pop_front();
				if (got.ok !== want.ok)
					note_mismatch("ok flag", want, got);
				else if (got.length !== want.length)
					note_mismatch("length", want, got);
			end
		end
	end

	// stimulus
	initial begin
		int unsigned n;
		int unsigned r;
		int unsigned grow_pct;
		logic [2:0]  op;
		logic [31:0] value;
		logic [2:0]  pos;

		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		shadow_len = 0;
		mismatch_cnt = 0;
		calm       = 1'b0;
		grow_pct   = 40;
		for (n = 0; n < DEPTH; n++)
			shadow_vals[n] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (n = 0; n < N_ROWS; n++)
			send_list_op(plan_rows[n].op, plan_rows[n].value, plan_rows[n].pos,
				plan_rows[n].typed, plan_rows[n].ok, plan_rows[n].length);

		// random: phases that fill, drain or churn the list
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 48 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 2);
				grow_pct = (r == 0) ? 56 : (r == 1) ? 24 : 40;
			end
			r = $urandom_range(0, 99);
			if (r < 2) begin
				op = OP_UNUSED;
			end else if (r < 20) begin
				op = bal_pkg::OP_SEARCH;
			end else if (r < 20 + grow_pct) begin
				case ($urandom_range(0, 2))
					0: op = bal_pkg::OP_INS_FRONT;
					1: op = bal_pkg::OP_APPEND;
					default: op = bal_pkg::OP_INS_POS;
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0: op = bal_pkg::OP_DEL_FRONT;
					1: op = bal_pkg::OP_DEL_END;
					default: op = bal_pkg::OP_DEL_POS;
				endcase
			end

			// positions cluster around the valid range and its edge
			r = $urandom_range(0, 3);
			if (r == 0 || shadow_len == 0)
				pos = 3'($urandom_range(0, 7));
			else if (r == 1)
				pos = (shadow_len > 7) ? 3'd7 : 3'(shadow_len);
			else
				pos = 3'($urandom_range(0, shadow_len - 1));

			// searches mostly look for stored values or near misses
			value = pick_value();
			if (op == bal_pkg::OP_SEARCH && shadow_len > 0 && $urandom_range(0, 9) < 7) begin
				value = shadow_vals[$urandom_range(0, shadow_len - 1)];
				if ($urandom_range(0, 3) == 0)
					value = value ^ (32'h1 << $urandom_range(0, 31));
			end

			send_list_op(op, value, pos, 1'b0, 1'b0, 4'd0);
		end
		s_tvalid <= 1'b0;

		// drain, then watch for stray beats
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== bounded_array_list.f =====
rtl/core/bal_pkg.sv
rtl/core/bal_ctrl.sv
rtl/core/bal_datapath.sv
rtl/core/bounded_array_list.sv
sim/tb_top.sv
